// File: design/vpt_pkg.sv
// Package for the vibration pattern timer: counter width, operation and
// mode codes, configuration and result structs, and the length fitting helper.
// No dependencies.
package vpt_pkg;

    // Width of the remaining-time counter (valid range 8 to 32).
    localparam int COUNT_WIDTH = 16;
    localparam int LEN_WIDTH   = 16;
    localparam int OP_WIDTH    = 2;
    localparam int MODE_WIDTH  = 3;
    localparam int CFG_IDX_W   = 2;

    // Operation codes carried in s_tuser.
    localparam logic [OP_WIDTH-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_WIDTH-1:0] OP_SHORT  = 2'd1;
    localparam logic [OP_WIDTH-1:0] OP_LONG   = 2'd2;
    localparam logic [OP_WIDTH-1:0] OP_REPEAT = 2'd3;

    // Mode codes.
    localparam logic [MODE_WIDTH-1:0] MODE_STOP    = 3'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_SHORT   = 3'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_LONG    = 3'd2;
    localparam logic [MODE_WIDTH-1:0] MODE_REP_ON  = 3'd3;
    localparam logic [MODE_WIDTH-1:0] MODE_REP_OFF = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REP_ON    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REP_OFF   = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [LEN_WIDTH-1:0] SHORT_LEN_RESET = 16'd300;
    localparam logic [LEN_WIDTH-1:0] REP_ON_RESET    = 16'd500;
    localparam logic [LEN_WIDTH-1:0] REP_OFF_RESET   = 16'd500;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [LEN_WIDTH-1:0]   len_t;
    typedef logic [OP_WIDTH-1:0]    op_t;
    typedef logic [MODE_WIDTH-1:0]  mode_t;

    typedef struct packed {
        len_t short_len;
        len_t rep_on;
        len_t rep_off;
    } cfg_t;

    typedef struct packed {
        logic  motor_on;
        mode_t mode;
    } result_t;

    // Fit a 16-bit length into the counter: truncate or zero-extend.
    function automatic count_t fit_count(input len_t len);
        logic [COUNT_WIDTH+LEN_WIDTH-1:0] wide;
        wide = {{COUNT_WIDTH{1'b0}}, len};
        return wide[COUNT_WIDTH-1:0];
    endfunction

endpackage

// File: design/vibration_pattern_timer.sv
// Vibration pattern timer top level: input register, step logic and result
// register. Depends on vpt_pkg, vpt_cfg_regs and vpt_step.
//
// Each input transfer is a one-millisecond tick or a command (short buzz,
// long buzz, repeating pattern) and yields exactly one result transfer with
// the motor enable and the mode after that item. The block takes one item
// per clock cycle while the result side does not stall; a result passes
// through the input register and then the result register, and the
// per-item work is a single compare, decrement and mode update. Back
// pressure on the result side stalls the input side only once both
// registers are full. Configuration writes take effect on the next cycle
// and should be made only while no item is in flight.
module vibration_pattern_timer
    import vpt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration write port.
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEN_WIDTH-1:0] cfg_wdata,
    // Input channel.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [15:0] duration_ms
    input  logic [1:0]           s_tuser,   // [1:0] operation
    // Result channel.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata    // [0] motor_on, [3:1] mode_now, [7:4] zero
);

    cfg_t    cfg;
    result_t result;

    logic    in_valid_reg;
    op_t     in_op_reg;
    len_t    in_dur_reg;
    logic    out_valid_reg;
    result_t out_reg;
    logic    out_free;
    logic    step_en;

    vpt_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Handshake: an item moves on when the result register can take it.
    assign out_free = !out_valid_reg || m_tready;
    assign step_en  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg  <= s_tuser;
            in_dur_reg <= s_tdata;
        end
    end

    vpt_step u_step (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (step_en),
        .op       (in_op_reg),
        .duration (in_dur_reg),
        .cfg      (cfg),
        .result   (result)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reg.mode, out_reg.motor_on};

    // The motor is driven exactly in the short, long and repeat-on modes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == ((m_tdata[3:1] == MODE_SHORT) ||
                                     (m_tdata[3:1] == MODE_LONG) ||
                                     (m_tdata[3:1] == MODE_REP_ON))))
        else $error("motor_on does not match mode_now");

    // A command always leaves the motor on.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && (in_op_reg != OP_TICK)) |=> (m_tvalid && m_tdata[0]))
        else $error("command result does not drive the motor");

    // An empty result register never stalls the input side.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with an empty result register");

endmodule

// File: design/vpt_cfg_regs.sv
// Configuration registers of the vibration pattern timer.
// Depends on vpt_pkg.
module vpt_cfg_regs
    import vpt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  len_t                 cfg_wdata,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write index; an index beyond the list changes nothing.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SHORT_LEN: cfg_next.short_len = cfg_wdata;
                CFG_REP_ON:    cfg_next.rep_on    = cfg_wdata;
                CFG_REP_OFF:   cfg_next.rep_off   = cfg_wdata;
                default:       cfg_next           = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.short_len <= SHORT_LEN_RESET;
            cfg_reg.rep_on    <= REP_ON_RESET;
            cfg_reg.rep_off   <= REP_OFF_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: design/vpt_step.sv
// Mode, counter and drive state of the vibration pattern timer with the
// next-state logic for one tick or command. Depends on vpt_pkg.
module vpt_step
    import vpt_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step_en,
    input  op_t     op,
    input  len_t    duration,
    input  cfg_t    cfg,
    output result_t result
);

    mode_t  mode_reg, mode_next;
    count_t remaining_reg, remaining_next;
    logic   drive_reg, drive_next;

    // Next state for the item in the input register.
    always_comb begin
        mode_next      = mode_reg;
        remaining_next = remaining_reg;
        drive_next     = drive_reg;
        unique case (op)
            OP_SHORT: begin
                mode_next      = MODE_SHORT;
                remaining_next = fit_count(cfg.short_len);
                drive_next     = 1'b1;
            end
            OP_LONG: begin
                mode_next      = MODE_LONG;
                remaining_next = fit_count(duration);
                drive_next     = 1'b1;
            end
            OP_REPEAT: begin
                mode_next      = MODE_REP_ON;
                remaining_next = fit_count(cfg.rep_on);
                drive_next     = 1'b1;
            end
            default: begin
                // A tick: count down, or act on expiry of a value of zero or one.
                if (mode_reg != MODE_STOP) begin
                    if (remaining_reg > COUNT_WIDTH'(1)) begin
                        remaining_next = remaining_reg - COUNT_WIDTH'(1);
                    end else begin
                        unique case (mode_reg)
                            MODE_REP_ON: begin
                                mode_next      = MODE_REP_OFF;
                                remaining_next = fit_count(cfg.rep_off);
                                drive_next     = 1'b0;
                            end
                            MODE_REP_OFF: begin
                                mode_next      = MODE_REP_ON;
                                remaining_next = fit_count(cfg.rep_on);
                                drive_next     = 1'b1;
                            end
                            default: begin
                                mode_next      = MODE_STOP;
                                remaining_next = '0;
                                drive_next     = 1'b0;
                            end
                        endcase
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_STOP;
            remaining_reg <= '0;
            drive_reg     <= 1'b0;
        end else if (step_en) begin
            mode_reg      <= mode_next;
            remaining_reg <= remaining_next;
            drive_reg     <= drive_next;
        end
    end

    // The result reports the state after this item.
    assign result.motor_on = drive_next;
    assign result.mode     = mode_next;

endmodule
